// ===== hw/rtl/srq_pkg.sv =====
// Package for the shift record queue: depth, index widths, record layout,
// operation and status codes. Depends on nothing.
`default_nettype none

package srq_pkg;

   localparam int QueueDepth = 32;
   localparam int AddrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CountW = $clog2(QueueDepth + 1);
   localparam int EntriesW = 6;

   typedef logic [AddrW-1:0] addr_type;
   typedef logic [CountW-1:0] count_type;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_LIST    = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_GIVEN = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0]  age;
      logic [31:0] name_tail;
      logic [63:0] name_mid;
      logic [63:0] name_low;
   } record_type;

endpackage

`default_nettype wire

// ===== hw/rtl/shift_record_queue.sv =====
// Top level of the shift record queue: a bounded first-in first-out queue of
// name and age records held in one synchronous memory. Depends on srq_pkg.
//
// Channel  Direction  Handshake                   Contents
// req_     in         req_tvalid / req_tready     tuser: operation; tdata: record
// rsp_     out        rsp_tvalid / rsp_tready     tuser: status; tlast; tdata: record, count
//
// Enqueue, clear and refused or empty operations are answered from the idle state.
// Dequeue registers the head record out of memory, then passes it on in the data state.
// List gives one result per stored record from the head, before taking a new item.
// Reset clears the state, count, head pointer and output valid flag; stored records stay.
// A stalled result holds the block until it is taken, with no loss.
`default_nettype none

module shift_record_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   // tdata: name_word0, name_word1, name_word2, age_in (low to high)
   input  wire  [167:0]       req_tdata,
   // tuser: operation
   input  wire  [1:0]         req_tuser,
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   // tdata: out_name_word0, out_name_word1, out_name_word2, age_out,
   // entries_held, two zero bits (low to high)
   output logic [175:0]       rsp_tdata,
   // tuser: op_status
   output logic [1:0]         rsp_tuser,
   output logic               rsp_tlast
);
   import srq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DATA = 2'b10
   } state_type;

   record_type mem [QueueDepth];
   record_type rd_data_ff;

   state_type state_ff, state_in;
   count_type count_ff, count_in;
   addr_type  head_ff, head_in;
   addr_type  list_addr_ff, list_addr_in;
   count_type list_idx_ff, list_idx_in;
   logic      deq_mode_ff, deq_mode_in;

   logic       rsp_valid_ff, rsp_valid_in;
   record_type rsp_rec_ff, rsp_rec_in;
   status_type rsp_status_ff, rsp_status_in;
   logic       rsp_last_ff, rsp_last_in;
   logic [EntriesW-1:0] rsp_entries_ff, rsp_entries_in;
   logic       rsp_load;

   logic       wr_en, rd_en;
   addr_type   wr_addr, rd_addr;
   logic [AddrW:0] tail_sum;
   logic       slot_free, req_fire, list_last;
   op_type     op;

   function automatic addr_type addr_next(input addr_type a);
      addr_type r;
      if (a == addr_type'(QueueDepth - 1)) begin
         r = '0;
      end else begin
         r = a + addr_type'(1);
      end
      return r;
   endfunction

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && slot_free;
   assign req_fire   = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign tail_sum   = {1'b0, head_ff} + (AddrW + 1)'(count_ff);
   assign list_last  = (list_idx_ff + count_type'(1)) == count_ff;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      list_addr_in   = list_addr_ff;
      list_idx_in    = list_idx_ff;
      deq_mode_in    = deq_mode_ff;
      rsp_load       = 1'b0;
      rsp_rec_in     = '0;
      rsp_status_in  = ST_DONE;
      rsp_last_in    = 1'b1;
      rsp_entries_in = EntriesW'(count_ff);
      wr_en          = 1'b0;
      wr_addr        = (tail_sum >= (AddrW + 1)'(QueueDepth))
                       ? AddrW'(tail_sum - (AddrW + 1)'(QueueDepth))
                       : AddrW'(tail_sum);
      rd_en          = 1'b0;
      rd_addr        = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (op)
                  OP_ENQUEUE: begin
                     rsp_load = 1'b1;
                     if (count_ff == count_type'(QueueDepth)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en          = 1'b1;
                        count_in       = count_ff + count_type'(1);
                        rsp_status_in  = ST_DONE;
                        rsp_entries_in = EntriesW'(count_ff + count_type'(1));
                     end
                  end
                  OP_CLEAR: begin
                     rsp_load       = 1'b1;
                     count_in       = '0;
                     rsp_status_in  = ST_DONE;
                     rsp_entries_in = '0;
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = head_ff;
                        list_addr_in = addr_next(head_ff);
                        list_idx_in  = '0;
                        deq_mode_in  = (op == OP_DEQUEUE);
                        state_in     = S_DATA;
                     end
                  end
               endcase
            end
         end
         S_DATA: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_rec_in    = rd_data_ff;
               rsp_status_in = ST_GIVEN;
               if (deq_mode_ff) begin
                  head_in        = addr_next(head_ff);
                  count_in       = count_ff - count_type'(1);
                  rsp_entries_in = EntriesW'(count_ff - count_type'(1));
                  state_in       = S_IDLE;
               end else begin
                  rsp_last_in = list_last;
                  if (list_last) begin
                     state_in = S_IDLE;
                  end else begin
                     rd_en        = 1'b1;
                     rd_addr      = list_addr_ff;
                     list_addr_in = addr_next(list_addr_ff);
                     list_idx_in  = list_idx_ff + count_type'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= record_type'(req_tdata);
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      list_addr_ff <= list_addr_in;
      list_idx_ff  <= list_idx_in;
      deq_mode_ff  <= deq_mode_in;
      if (rsp_load) begin
         rsp_rec_ff     <= rsp_rec_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_last_ff    <= rsp_last_in;
         rsp_entries_ff <= rsp_entries_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_entries_ff, rsp_rec_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for shift_record_queue: directed and shaped random
// enqueue, dequeue, list and clear items under varied idling. Depends on srq_pkg.
`timescale 1ns / 1ps

module tb;
   import srq_pkg::*;

   localparam int ClockPeriod = 4;
   localparam int ResetCycles = 7;
   localparam int RandomItems = 360;
   localparam int PhaseLength = 45;
   localparam int SettleCycles = 16;
   localparam int WatchdogLimit = 2000;

   typedef struct {
      op_type     op;
      record_type rec;
      bit         drain_first;
      int         send_idle;
      int         rsp_stall;
   } queue_request_type;

   typedef struct {
      status_type status;
      record_type rec;
      logic       last;
      logic [5:0] held;
   } queue_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [167:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b1;
   logic [175:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;

   queue_request_type request_backlog[$];
   queue_reply_type awaited_replies[$];
   record_type model_records[$];

   bit results_outstanding = 1'b0;
   int stall_pct = 0;
   int gen_fill = 0;
   int gen_phase_count = 0;
   int total_requests = 0;
   int accepted_requests = 0;
   int replies_checked = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   int op_counts[4] = '{0, 0, 0, 0};
   int full_refusals = 0;
   int empty_replies = 0;
   int longest_listing = 0;

   shift_record_queue uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   function automatic logic [63:0] rand_word64();
      return {$urandom, $urandom};
   endfunction

   function automatic record_type rand_record();
      record_type rec;
      rec.name_low = rand_word64();
      rec.name_mid = rand_word64();
      rec.name_tail = $urandom;
      rec.age = 8'($urandom_range(255));
      return rec;
   endfunction

   function automatic queue_reply_type make_reply(status_type status, record_type rec,
                                                  logic last);
      queue_reply_type reply;
      reply.status = status;
      reply.rec = rec;
      reply.last = last;
      reply.held = 6'(model_records.size());
      return reply;
   endfunction

   // Expected results of one accepted item; the record list mirrors the queue contents.
   function automatic void predict_queue_op(op_type op, record_type rec);
      record_type head;
      op_counts[op]++;
      case (op)
         OP_ENQUEUE: begin
            if (model_records.size() >= QueueDepth) begin
               full_refusals++;
               awaited_replies.push_back(make_reply(ST_FULL, '0, 1'b1));
            end else begin
               model_records.push_back(rec);
               awaited_replies.push_back(make_reply(ST_DONE, '0, 1'b1));
            end
         end
         OP_DEQUEUE: begin
            if (model_records.size() == 0) begin
               empty_replies++;
               awaited_replies.push_back(make_reply(ST_EMPTY, '0, 1'b1));
            end else begin
               head = model_records.pop_front();
               awaited_replies.push_back(make_reply(ST_GIVEN, head, 1'b1));
            end
         end
         OP_LIST: begin
            if (model_records.size() == 0) begin
               empty_replies++;
               awaited_replies.push_back(make_reply(ST_EMPTY, '0, 1'b1));
            end else begin
               if (model_records.size() > longest_listing) longest_listing = model_records.size();
               foreach (model_records[i]) begin
                  awaited_replies.push_back(make_reply(ST_GIVEN, model_records[i],
                                                       i == model_records.size() - 1));
               end
            end
         end
         default: begin
            model_records.delete();
            awaited_replies.push_back(make_reply(ST_DONE, '0, 1'b1));
         end
      endcase
   endfunction

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatches++;
      end
   endtask

   task automatic check_reply();
      queue_reply_type want;
      if (awaited_replies.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual status %h tdata %h",
                  $time, rsp_tuser, rsp_tdata);
         mismatches++;
      end else begin
         want = awaited_replies.pop_front();
         replies_checked++;
         compare_field("op_status", 64'(want.status), 64'(rsp_tuser));
         compare_field("out_name_word0", want.rec.name_low, rsp_tdata[63:0]);
         compare_field("out_name_word1", want.rec.name_mid, rsp_tdata[127:64]);
         compare_field("out_name_word2", 64'(want.rec.name_tail), 64'(rsp_tdata[159:128]));
         compare_field("age_out", 64'(want.rec.age), 64'(rsp_tdata[167:160]));
         compare_field("entries_held", 64'(want.held), 64'(rsp_tdata[173:168]));
         compare_field("tdata padding", 64'(0), 64'(rsp_tdata[175:174]));
         compare_field("last_of_run", 64'(want.last), 64'(rsp_tlast));
      end
   endtask

   task automatic add_request(input op_type op, input record_type rec, input bit drain_first,
                              input bit directed);
      queue_request_type item;
      int phase;
      phase = directed ? 0 : (gen_phase_count / PhaseLength) % 4;
      if (!directed) gen_phase_count++;
      item.op = op;
      item.rec = rec;
      item.drain_first = drain_first;
      item.send_idle = (phase == 1) ? 69 : (phase == 3) ? 17 : 0;
      item.rsp_stall = (phase == 2) ? 69 : (phase == 3) ? 17 : 0;
      request_backlog.push_back(item);
      total_requests++;
      case (op)
         OP_ENQUEUE: if (gen_fill < QueueDepth) gen_fill++;
         OP_DEQUEUE: if (gen_fill > 0) gen_fill--;
         OP_CLEAR: gen_fill = 0;
         default: ;
      endcase
   endtask

   task automatic build_directed();
      record_type pattern;
      add_request(OP_DEQUEUE, rand_record(), 1'b0, 1'b1);
      add_request(OP_LIST, rand_record(), 1'b0, 1'b1);
      add_request(OP_CLEAR, rand_record(), 1'b0, 1'b1);
      add_request(OP_ENQUEUE, '0, 1'b0, 1'b1);
      add_request(OP_ENQUEUE, '1, 1'b0, 1'b1);
      add_request(OP_ENQUEUE, rand_record(), 1'b0, 1'b1);
      add_request(OP_LIST, rand_record(), 1'b0, 1'b1);
      add_request(OP_DEQUEUE, '1, 1'b0, 1'b1);
      add_request(OP_LIST, '0, 1'b0, 1'b1);
      add_request(OP_CLEAR, '1, 1'b0, 1'b1);
      add_request(OP_LIST, rand_record(), 1'b0, 1'b1);
      add_request(OP_DEQUEUE, rand_record(), 1'b0, 1'b1);
      pattern = {8'h55, 32'h5555_5555, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555};
      add_request(OP_ENQUEUE, pattern, 1'b0, 1'b1);
      add_request(OP_ENQUEUE, ~pattern, 1'b0, 1'b1);
      add_request(OP_LIST, rand_record(), 1'b0, 1'b1);
      add_request(OP_DEQUEUE, rand_record(), 1'b0, 1'b1);
      add_request(OP_DEQUEUE, rand_record(), 1'b0, 1'b1);
      add_request(OP_DEQUEUE, rand_record(), 1'b0, 1'b1);
      add_request(OP_LIST, rand_record(), 1'b0, 1'b1);
   endtask

   // Fill and drain runs reach the full and empty corners; mixed runs add noise.
   task automatic build_random();
      int pick;
      int draw;
      bit pause;
      pause = 1'b1;
      while (gen_phase_count < RandomItems) begin
         pick = $urandom_range(9);
         if (pick < 3) begin
            add_request(OP_ENQUEUE, rand_record(), pause, 1'b0);
            while (gen_fill < QueueDepth) add_request(OP_ENQUEUE, rand_record(), 1'b0, 1'b0);
            repeat ($urandom_range(3, 1)) add_request(OP_ENQUEUE, rand_record(), 1'b0, 1'b0);
            add_request(OP_LIST, rand_record(), 1'b0, 1'b0);
         end else if (pick < 5) begin
            add_request(OP_DEQUEUE, rand_record(), pause, 1'b0);
            while (gen_fill > 0) add_request(OP_DEQUEUE, rand_record(), 1'b0, 1'b0);
            add_request(OP_DEQUEUE, rand_record(), 1'b0, 1'b0);
            add_request(OP_LIST, rand_record(), 1'b0, 1'b0);
         end else begin
            repeat (12) begin
               draw = $urandom_range(99);
               if (draw < 45) add_request(OP_ENQUEUE, rand_record(), pause, 1'b0);
               else if (draw < 75) add_request(OP_DEQUEUE, rand_record(), pause, 1'b0);
               else if (draw < 88) add_request(OP_LIST, rand_record(), pause, 1'b0);
               else add_request(OP_CLEAR, rand_record(), pause, 1'b0);
               pause = 1'b0;
            end
         end
         pause = ($urandom_range(3) == 0);
      end
   endtask

   always @(posedge clock) begin
      queue_request_type head_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (request_backlog.size() == 0 ||
             (request_backlog[0].drain_first && (req_tvalid || results_outstanding)) ||
             $urandom_range(99) < request_backlog[0].send_idle) begin
            req_tvalid <= 1'b0;
         end else begin
            head_item = request_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= head_item.op;
            req_tdata <= head_item.rec;
            stall_pct <= head_item.rsp_stall;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         results_outstanding <= 1'b0;
      end else begin
         if (rsp_tvalid === 1'b1 && rsp_tready) check_reply();
         if (req_tvalid && req_tready === 1'b1) begin
            predict_queue_op(op_type'(req_tuser), record_type'(req_tdata));
            accepted_requests++;
         end
         results_outstanding <= (awaited_replies.size() != 0);
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready === 1'b1) ||
          (rsp_tvalid === 1'b1 && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("%0t: timeout, no handshake for %0d cycles, %0d results still awaited",
                  $time, quiet_cycles, awaited_replies.size());
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      build_directed();
      build_random();
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      while (accepted_requests < total_requests) @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      $display("Ran %0d items: %0d enqueue, %0d dequeue, %0d list, %0d clear; %0d results %s",
               accepted_requests, op_counts[OP_ENQUEUE], op_counts[OP_DEQUEUE],
               op_counts[OP_LIST], op_counts[OP_CLEAR], replies_checked, "checked.");
      $display("Saw %0d refusals on a full queue, %0d empty results, longest listing %0d records.",
               full_refusals, empty_replies, longest_listing);
      if (mismatches == 0 && awaited_replies.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
